@@ rtl/core/lfo_pkg.sv @@
// Shared types, register indexes and reset values of the LFO phase accumulator adder.
`timescale 1ns / 1ps

package lfo_pkg;

    // Register indexes on the configuration write channel.
    localparam logic [1:0] CFG_TARGET_STEP = 2'd0;
    localparam logic [1:0] CFG_SLEW_DELTA  = 2'd1;
    localparam logic [1:0] CFG_WAVE_SELECT = 2'd2;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int STEP_BITS      = 31;

    localparam logic [STEP_BITS-1:0] TARGET_STEP_RESET = 31'd89478;
    localparam logic [STEP_BITS-1:0] SLEW_DELTA_RESET  = 31'd64;

    // Half pi in unsigned Q2.30.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SAW    = 2'd1,
        WAVE_SQUARE = 2'd2
    } wave_t;

    typedef struct packed {
        logic [STEP_BITS-1:0] target_step;
        logic [STEP_BITS-1:0] slew_delta;
        logic [1:0]           wave_select;
    } cfg_t;

endpackage

@@ rtl/core/lfo_ifs.sv @@
// Request channels of the LFO phase accumulator adder: samples in, results out, register writes.
`timescale 1ns / 1ps

interface lfo_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface lfo_result_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface lfo_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lfo_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [lfo_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/lfo_phase_accumulator_adder.sv @@
// Top level of the LFO phase accumulator adder: request pipeline, oscillator and saturation.
`timescale 1ns / 1ps

// This block adds a low-frequency oscillator to an audio stream, one result per
// input request. The oscillator is a direct digital synthesis phase accumulator
// whose step slews toward target_step by at most slew_delta per sample; the
// waveform (sine from a quarter-wave table, saw or square) is taken from the
// phase before it advances, and the sum saturates to the sample width. The
// block takes one request every clock cycle while the downstream side takes
// its results. The first register captures the sample and the phase while
// the accumulator and step advance, the second holds the saturated sum until
// the downstream side takes it. A waiting result keeps the next request out
// only once the first register also holds a request that cannot move on. The
// sine table is a constant table built at elaboration and read in the second
// stage. Registers are written through the configuration channel, which is
// always ready, and are meant to be changed only while no request is in flight;
// writes to the unused index are ignored.

module lfo_phase_accumulator_adder #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int PHASE_BITS       = 32,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    lfo_sample_if.sink    sample_chan,
    lfo_result_if.source  result_chan,
    lfo_cfg_if.sink       cfg_chan
);

    lfo_pkg::cfg_t cfg;

    lfo_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_chan (cfg_chan),
        .cfg      (cfg)
    );

    // Handshake of the two pipeline stages.
    logic accept;
    logic s1_ready;
    logic out_load;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [PHASE_BITS-1:0]         s1_phase_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_next;

    logic [PHASE_BITS-1:0]         phase;
    logic signed [SAMPLE_BITS-1:0] osc;
    logic signed [SAMPLE_BITS:0]   sum;

    // The result stage loads whenever it is empty or its result leaves this cycle.
    assign out_load          = !out_valid_reg || result_chan.ready;
    assign s1_ready          = !s1_valid_reg || out_load;
    assign sample_chan.ready = s1_ready;
    assign accept            = sample_chan.valid && s1_ready;

    lfo_phase_gen #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .cfg     (cfg),
        .phase   (phase)
    );

    lfo_wave_gen #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_wave_gen (
        .phase       (s1_phase_reg),
        .wave_select (cfg.wave_select),
        .osc         (osc)
    );

    // One bit of headroom is enough for the sum of two full-range values.
    assign sum = (SAMPLE_BITS+1)'(s1_sample_reg) + (SAMPLE_BITS+1)'(osc);

    always_comb
    begin
        if (sum[SAMPLE_BITS] != sum[SAMPLE_BITS-1])
            out_sample_next = sum[SAMPLE_BITS] ? $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}})
                                               : $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        else
            out_sample_next = sum[SAMPLE_BITS-1:0];
    end

    always_comb
    begin
        s1_valid_next  = s1_ready ? sample_chan.valid : s1_valid_reg;
        out_valid_next = out_load ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The sample and the phase before this step travel together to the second stage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample_chan.sample_in;
            s1_phase_reg  <= phase;
        end
        if (out_load && s1_valid_reg)
            out_sample_reg <= out_sample_next;
    end

    assign result_chan.valid      = out_valid_reg;
    assign result_chan.sample_out = out_sample_reg;

endmodule

@@ rtl/core/lfo_cfg_regs.sv @@
// Configuration register file of the LFO phase accumulator adder.
`timescale 1ns / 1ps

module lfo_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    lfo_cfg_if.sink       cfg_chan,
    output lfo_pkg::cfg_t cfg
);

    lfo_pkg::cfg_t cfg_reg;
    lfo_pkg::cfg_t cfg_next;

    assign cfg_chan.ready = 1'b1;
    assign cfg            = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_chan.valid)
        begin
            unique case (cfg_chan.index)
                lfo_pkg::CFG_TARGET_STEP:
                    cfg_next.target_step = cfg_chan.data[lfo_pkg::STEP_BITS-1:0];
                lfo_pkg::CFG_SLEW_DELTA:
                    cfg_next.slew_delta = cfg_chan.data[lfo_pkg::STEP_BITS-1:0];
                lfo_pkg::CFG_WAVE_SELECT:
                    cfg_next.wave_select = cfg_chan.data[1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_step <= lfo_pkg::TARGET_STEP_RESET;
            cfg_reg.slew_delta  <= lfo_pkg::SLEW_DELTA_RESET;
            cfg_reg.wave_select <= lfo_pkg::WAVE_SINE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/core/lfo_phase_gen.sv @@
// Phase accumulator with a slewed phase step for the LFO.
`timescale 1ns / 1ps

module lfo_phase_gen #(
    parameter int PHASE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  lfo_pkg::cfg_t         cfg,
    output logic [PHASE_BITS-1:0] phase
);

    logic [lfo_pkg::STEP_BITS-1:0] current_step_reg;
    logic [lfo_pkg::STEP_BITS-1:0] current_step_next;
    logic [PHASE_BITS-1:0]         phase_acc_reg;
    logic [PHASE_BITS-1:0]         phase_acc_next;
    logic [lfo_pkg::STEP_BITS-1:0] gap;
    logic [lfo_pkg::STEP_BITS-1:0] move;
    logic [32:0]                   phase_sum;

    // The step moves toward the target by at most the slew delta; it never overshoots.
    always_comb
    begin
        gap  = (current_step_reg < cfg.target_step) ? cfg.target_step - current_step_reg
                                                    : current_step_reg - cfg.target_step;
        move = (gap < cfg.slew_delta) ? gap : cfg.slew_delta;
        if (current_step_reg < cfg.target_step)
            current_step_next = current_step_reg + move;
        else
            current_step_next = current_step_reg - move;
    end

    // The phase advances by the updated step and wraps on its own width.
    assign phase_sum      = 33'(phase_acc_reg) + 33'(current_step_next);
    assign phase_acc_next = phase_sum[PHASE_BITS-1:0];
    assign phase          = phase_acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_step_reg <= '0;
            phase_acc_reg    <= '0;
        end
        else if (advance)
        begin
            current_step_reg <= current_step_next;
            phase_acc_reg    <= phase_acc_next;
        end
    end

endmodule

@@ rtl/core/lfo_wave_gen.sv @@
// Waveform generator of the LFO: quarter-wave sine table, saw and square.
`timescale 1ns / 1ps

module lfo_wave_gen #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int PHASE_BITS       = 32,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic [PHASE_BITS-1:0]         phase,
    input  logic [1:0]                    wave_select,
    output logic signed [SAMPLE_BITS-1:0] osc
);

    localparam int          IDX_BITS   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int          FRAC_BITS  = PHASE_BITS - 2;
    localparam logic [63:0] FULL_SCALE = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    localparam logic [IDX_BITS-1:0] DEPTH_CODE = IDX_BITS'(SINE_TABLE_DEPTH);

    // Truncated Taylor series of sin in unsigned Q2.30, scaled to full scale.
    function automatic logic [63:0] rom_entry(input logic [63:0] k);
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        th   = (lfo_pkg::HALF_PI_Q30 * k) / 64'(SINE_TABLE_DEPTH);
        th2  = (th * th) >> 30;
        sum  = th;
        term = ((th * th2) >> 30) / 64'd6;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * th2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * th2) >> 30) / 64'd42;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * th2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * th2) >> 30) / 64'd110;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * th2) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((term * th2) >> 30) / 64'd210;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * th2) >> 30) / 64'd272;
        sum  = sum + term;
        v    = (sum * FULL_SCALE + (64'd1 << 29)) >> 30;
        if (v > FULL_SCALE)
            v = FULL_SCALE;
        return v;
    endfunction

    logic [SAMPLE_BITS-2:0] sine_rom [0:SINE_TABLE_DEPTH];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++)
    begin : g_rom
        localparam logic [63:0] ENTRY = rom_entry(64'(g));
        assign sine_rom[g] = ENTRY[SAMPLE_BITS-2:0];
    end

    logic [PHASE_BITS-1:0]          u;
    logic [1:0]                     quadrant;
    logic [FRAC_BITS+IDX_BITS-1:0]  idx_prod;
    logic [IDX_BITS-1:0]            idx;
    logic [IDX_BITS-1:0]            rom_addr;
    logic [SAMPLE_BITS-1:0]         sine_mag;
    logic signed [SAMPLE_BITS-1:0]  sine_val;
    logic [SAMPLE_BITS-1:0]         ramp_top;
    logic signed [SAMPLE_BITS-1:0]  saw_val;
    logic signed [SAMPLE_BITS-1:0]  square_val;

    // Inverting the top bit starts the wave half a period early.
    assign u        = {~phase[PHASE_BITS-1], phase[PHASE_BITS-2:0]};
    assign quadrant = u[PHASE_BITS-1 -: 2];
    assign idx_prod = (FRAC_BITS+IDX_BITS)'(u[FRAC_BITS-1:0]) * DEPTH_CODE;
    assign idx      = idx_prod[FRAC_BITS+IDX_BITS-1:FRAC_BITS];
    assign rom_addr = quadrant[0] ? DEPTH_CODE - idx : idx;
    assign sine_mag = {1'b0, sine_rom[rom_addr]};
    assign sine_val = quadrant[1] ? -$signed(sine_mag) : $signed(sine_mag);

    if (PHASE_BITS >= SAMPLE_BITS)
    begin : g_ramp_trunc
        assign ramp_top = phase[PHASE_BITS-1 -: SAMPLE_BITS];
    end
    else
    begin : g_ramp_pad
        assign ramp_top = {phase, {(SAMPLE_BITS-PHASE_BITS){1'b0}}};
    end

    // Subtracting half of full range is an inversion of the top bit.
    assign saw_val    = $signed({~ramp_top[SAMPLE_BITS-1], ramp_top[SAMPLE_BITS-2:0]});
    assign square_val = phase[PHASE_BITS-1] ? $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}})
                                            : $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}});

    always_comb
    begin
        unique case (wave_select)
            lfo_pkg::WAVE_SINE:   osc = sine_val;
            lfo_pkg::WAVE_SAW:    osc = saw_val;
            lfo_pkg::WAVE_SQUARE: osc = square_val;
            default:              osc = '0;
        endcase
    end

endmodule
